// ===== sv/gamepad_report_translator_assert.svh =====
`ifndef GAMEPAD_REPORT_TRANSLATOR_ASSERT_SVH
`define GAMEPAD_REPORT_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define GRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define GRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/grt_pkg.sv =====
package grt_pkg;

	localparam int PAD_W    = 2;
	localparam int AXIS_W   = 16;
	localparam int AXES     = 4;
	localparam int DELTA_W  = AXIS_W + 1;
	localparam int DZ_W     = 15;
	localparam int POS_W    = 8;

	localparam int S_DATA_W   = 120;
	localparam int S_USER_W   = 9;
	localparam int M_DATA_W   = 72;
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-3:0] REG_DEAD_ZONE = 1'b0;

	localparam logic [7:0]      REPORT_KIND     = 8'h20;
	localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 15'd12000;
	localparam logic [15:0]     TRIG_SAT        = 16'h03FF;

	// Vertical axes (ly, ry) are inverted
	localparam logic [AXES-1:0] AXIS_INVERT = 4'b1010;

	typedef logic [AXES-1:0][AXIS_W-1:0] axis_row_t;

	typedef struct packed {
		logic             wr_en;
		logic             clr_en;
		logic [PAD_W-1:0] pad;
		axis_row_t        data;
	} store_upd_t;

	typedef struct packed {
		logic      valid;
		axis_row_t row;
	} store_rsp_t;

endpackage

// ===== sv/gamepad_report_translator.sv =====
// Pipeline: an accepted report passes through the stage 1, stage 2 and output registers to m_*.
// Throughput: one transaction per cycle unless m_tready stalls; calibration memory is read
// at acceptance, written back from stage 1, with a forwarding register for the same slot.
// Reset: clears pipeline and output valids and all calibration-valid bits, and loads
// dead_zone with 12000; calibration memory contents are not cleared.
module gamepad_report_translator #(
	parameter int PAD_SLOTS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [grt_pkg::ADDR_W-1:0]     paddr,
	input  logic [grt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [grt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// pad_index, face_buttons, pad_buttons, left_trigger, right_trigger,
	// stick_lx, stick_ly, stick_rx, stick_ry, zero fill
	input  logic [grt_pkg::S_DATA_W-1:0]   s_tdata,
	// action, packet_kind
	input  logic [grt_pkg::S_USER_W-1:0]   s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_pad, buttons_n, pressure_l2, pressure_r2, left_x, left_y, right_x, right_y,
	// zero fill
	output logic [grt_pkg::M_DATA_W-1:0]   m_tdata
);

	localparam int AXES = grt_pkg::AXES;

	logic [grt_pkg::DZ_W-1:0] dead_zone_q;
	logic                     cfg_sel;

	logic                         s_accept;
	logic [grt_pkg::PAD_W-1:0]    in_pad;
	grt_pkg::axis_row_t           in_axes;

	logic                         valid_s1;
	logic [grt_pkg::PAD_W-1:0]    pad_s1;
	logic                         action_s1;
	logic                         kind_ok_s1;
	logic                         in_range_s1;
	logic [7:0]                   face_s1;
	logic [7:0]                   padb_s1;
	logic [15:0]                  lt_s1;
	logic [15:0]                  rt_s1;
	grt_pkg::axis_row_t           raw_s1;

	logic                         report_s1;
	logic                         release_s1;
	grt_pkg::axis_row_t           centre;
	logic [AXES-1:0][grt_pkg::DELTA_W-1:0] delta;
	logic [15:0]                  pressed;

	logic                         valid_s2;
	logic [grt_pkg::PAD_W-1:0]    pad_s2;
	logic [15:0]                  buttons_n_s2;
	logic [7:0]                   l2_s2;
	logic [7:0]                   r2_s2;
	logic [AXES-1:0][grt_pkg::DELTA_W-1:0] delta_s2;

	logic [AXES-1:0][grt_pkg::POS_W-1:0] pos;

	logic                         out_valid_q;
	logic [grt_pkg::M_DATA_W-1:0] out_data_q;
	logic                         out_load;
	logic                         s2_free;
	logic                         s1_go;

	grt_pkg::store_upd_t upd;
	grt_pkg::store_rsp_t rsp;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[grt_pkg::ADDR_W-1:2] == grt_pkg::REG_DEAD_ZONE);
	assign prdata  = cfg_sel ? grt_pkg::APB_DATA_W'(dead_zone_q) : '0;

	// Flow control
	assign out_load = valid_s2 && (!out_valid_q || m_tready);
	assign s2_free  = !valid_s2 || out_load;
	assign s1_go    = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign s_accept = s_tvalid && s_tready;

	assign in_pad  = s_tdata[1:0];
	assign in_axes = {s_tdata[113:98], s_tdata[97:82], s_tdata[81:66], s_tdata[65:50]};

	grt_centre_store #(
		.PAD_SLOTS(PAD_SLOTS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept),
		.rd_pad  (in_pad),
		.look_pad(pad_s1),
		.upd     (upd),
		.rsp     (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= grt_pkg::DEAD_ZONE_RESET;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && cfg_sel) begin
				dead_zone_q <= pwdata[grt_pkg::DZ_W-1:0];
			end
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			// drop releases, foreign reports and out-of-range pads here
			if (s1_go) begin
				valid_s2 <= report_s1;
			end else if (out_load) begin
				valid_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1: calibration lookup, deltas, buttons, pressures
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pad_s1      <= in_pad;
			action_s1   <= s_tuser[0];
			kind_ok_s1  <= (s_tuser[8:1] == grt_pkg::REPORT_KIND);
			in_range_s1 <= (32'(in_pad) < PAD_SLOTS);
			face_s1     <= s_tdata[9:2];
			padb_s1     <= s_tdata[17:10];
			lt_s1       <= s_tdata[33:18];
			rt_s1       <= s_tdata[49:34];
			raw_s1      <= in_axes;
		end
	end

	assign report_s1  = in_range_s1 && !action_s1 && kind_ok_s1;
	assign release_s1 = in_range_s1 && action_s1;

	// First report of a slot becomes its centre
	assign upd.wr_en  = s1_go && report_s1 && !rsp.valid;
	assign upd.clr_en = s1_go && release_s1;
	assign upd.pad    = pad_s1;
	assign upd.data   = raw_s1;

	always_comb begin
		centre = rsp.valid ? rsp.row : raw_s1;
		for (int a = 0; a < AXES; a++) begin
			if (grt_pkg::AXIS_INVERT[a]) begin
				delta[a] = {centre[a][15], centre[a]} - {raw_s1[a][15], raw_s1[a]};
			end else begin
				delta[a] = {raw_s1[a][15], raw_s1[a]} - {centre[a][15], centre[a]};
			end
		end
		pressed = {face_s1[6], face_s1[4], face_s1[5], face_s1[7],
			padb_s1[5], padb_s1[4], (rt_s1 != 16'd0), (lt_s1 != 16'd0),
			padb_s1[2], padb_s1[1], padb_s1[3], padb_s1[0],
			face_s1[2], padb_s1[7], padb_s1[6], face_s1[3]};
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			pad_s2       <= pad_s1;
			buttons_n_s2 <= ~pressed;
			l2_s2        <= (lt_s1 > grt_pkg::TRIG_SAT) ? 8'hFF : lt_s1[9:2];
			r2_s2        <= (rt_s1 > grt_pkg::TRIG_SAT) ? 8'hFF : rt_s1[9:2];
			delta_s2     <= delta;
		end
	end

	// Stage 2: dead zone, scale and clamp
	for (genvar g = 0; g < AXES; g++) begin : g_axis
		grt_axis_map u_map (
			.delta    ($signed(delta_s2[g])),
			.dead_zone(dead_zone_q),
			.pos      (pos[g])
		);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'b0, pos[3], pos[2], pos[1], pos[0],
				r2_s2, l2_s2, buttons_n_s2, pad_s2};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== sv/grt_centre_store.sv =====
module grt_centre_store #(
	parameter int PAD_SLOTS = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [grt_pkg::PAD_W-1:0] rd_pad,
	input  logic [grt_pkg::PAD_W-1:0] look_pad,
	input  grt_pkg::store_upd_t       upd,
	output grt_pkg::store_rsp_t       rsp
);

	localparam int AW = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;

	grt_pkg::axis_row_t   mem [PAD_SLOTS];
	grt_pkg::axis_row_t   rd_row_q;
	grt_pkg::axis_row_t   fwd_row_q;
	logic                 fwd_hit_q;
	logic [PAD_SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (upd.wr_en) begin
			mem[AW'(upd.pad)] <= upd.data;
		end
		if (rd_en) begin
			rd_row_q  <= mem[AW'(rd_pad)];
			fwd_row_q <= upd.data;
		end
	end

	// Capture a row written in the same cycle as the read of the same slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
			valid_q   <= '0;
		end else begin
			if (rd_en) begin
				fwd_hit_q <= upd.wr_en && (upd.pad == rd_pad);
			end
			if (upd.wr_en) begin
				valid_q[AW'(upd.pad)] <= 1'b1;
			end
			if (upd.clr_en) begin
				valid_q[AW'(upd.pad)] <= 1'b0;
			end
		end
	end

	assign rsp.valid = valid_q[AW'(look_pad)];
	assign rsp.row   = fwd_hit_q ? fwd_row_q : rd_row_q;

endmodule

// ===== sv/grt_axis_map.sv =====
module grt_axis_map (
	input  logic signed [grt_pkg::DELTA_W-1:0] delta,
	input  logic        [grt_pkg::DZ_W-1:0]    dead_zone,
	output logic        [grt_pkg::POS_W-1:0]   pos
);

	logic signed [grt_pkg::DELTA_W-1:0] dz;
	logic signed [grt_pkg::DELTA_W-1:0] kept;
	logic                               in_dz;
	logic signed [9:0]                  sum;

	always_comb begin
		dz    = $signed({2'b00, dead_zone});
		in_dz = (delta < dz) && (delta > -dz);
		kept  = in_dz ? '0 : delta;
		// floor(kept / 256) + 128
		sum   = $signed({kept[grt_pkg::DELTA_W-1], kept[grt_pkg::DELTA_W-1:8]}) + 10'sd128;
		if (sum[9]) begin
			pos = '0;
		end else if (sum[8]) begin
			pos = '1;
		end else begin
			pos = sum[7:0];
		end
	end

endmodule

// ===== sv/grt_port_checker.sv =====
`include "gamepad_report_translator_assert.svh"

module grt_port_checker #(
	parameter int PAD_SLOTS = 4
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [grt_pkg::M_DATA_W-1:0] m_tdata
);

	`GRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
	`GRT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata moved while stalled")
	`GRT_ASSERT_NOW(a_in_ready, !m_tvalid || m_tready, s_tready, "input stalled with a free output")
	`GRT_ASSERT_NOW(a_pad_range, m_tvalid, 32'(m_tdata[1:0]) < PAD_SLOTS, "result for unknown pad")
	`GRT_ASSERT_NOW(a_l2_idle, m_tvalid && m_tdata[10], m_tdata[25:18] == 8'd0, "L2 pressure without L2")

endmodule

bind gamepad_report_translator grt_port_checker #(
	.PAD_SLOTS(PAD_SLOTS)
) u_port_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
